FILE: rtl/gopen_pkg.sv
package gopen_pkg;

  // Default geometry limits
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int BORDER_DEF    = 3;

  // Configuration register layout
  localparam int FW_W   = 12;
  localparam int FH_W   = 13;
  localparam int CFG_DW = 13;
  localparam int CFG_IW = 1;

  localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam int MIN_DIM = 7;
  localparam int W_RESET = 640;
  localparam int H_RESET = 480;

  // Slot row reaches H+2 during the flush tail
  localparam int ROW_W = 14;
  // Width of the position arithmetic in the slot tracker
  localparam int SUM_W = 16;

  localparam logic [7:0] PIX_ZERO = 8'h00;

  typedef logic [7:0] pix_t;

  // One window column: top is two lines back, bot is the newest line
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col3_t;

  // Index 0 is the newest column, index 2 the oldest
  typedef col3_t [2:0] win_t;

  // Line buffer word: pixel one line back and pixel two lines back
  typedef struct packed {
    pix_t prev1;
    pix_t prev2;
  } lpair_t;

  // Per-slot decisions made when the request enters
  typedef struct packed {
    logic e_int;
    logic o_vld;
    logic o_int;
    logic o_last;
  } slot_t;

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pix_t min9(win_t w);
    pix_t c0;
    pix_t c1;
    pix_t c2;
    c0 = min3(w[0].top, w[0].mid, w[0].bot);
    c1 = min3(w[1].top, w[1].mid, w[1].bot);
    c2 = min3(w[2].top, w[2].mid, w[2].bot);
    return min3(c0, c1, c2);
  endfunction

  function automatic pix_t max9(win_t w);
    pix_t c0;
    pix_t c1;
    pix_t c2;
    c0 = max3(w[0].top, w[0].mid, w[0].bot);
    c1 = max3(w[1].top, w[1].mid, w[1].bot);
    c2 = max3(w[2].top, w[2].mid, w[2].bot);
    return max3(c0, c1, c2);
  endfunction

endpackage

FILE: rtl/gopen_if.sv
interface gopen_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;
  logic       fill;

  modport source (output valid, output pixel_in, output fill, input ready);
  modport sink   (input valid, input pixel_in, input fill, output ready);
endinterface

interface gopen_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

FILE: rtl/gopen_lbuf.sv
module gopen_lbuf #(
  parameter int DEPTH = gopen_pkg::MAX_WIDTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output gopen_pkg::lpair_t  rd_data_o,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  gopen_pkg::lpair_t  wr_data_i
);

  gopen_pkg::lpair_t mem_q [DEPTH];
  gopen_pkg::lpair_t rd_q;

  // Read data holds while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: rtl/gopen_win.sv
module gopen_win (
  input  logic              clk_i,
  input  logic              shift_i,
  input  gopen_pkg::col3_t  col_i,
  output gopen_pkg::win_t   win_o
);

  gopen_pkg::win_t win_q;

  // Shift the new column in at the newest end
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q <= {win_q[1:0], col_i};
    end
  end

  assign win_o = win_q;

endmodule

FILE: rtl/gopen_ctrl.sv
module gopen_ctrl #(
  parameter int MAX_WIDTH = gopen_pkg::MAX_WIDTH_DEF,
  parameter int BORDER    = gopen_pkg::BORDER_DEF,
  localparam int CW       = $clog2(MAX_WIDTH),
  localparam int WVW      = CW + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gopen_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [gopen_pkg::CFG_DW-1:0]  cfg_data_i,
  input  logic                          acc_i,
  input  logic                          fill_i,
  output logic                          admit_o,
  output logic [CW-1:0]                 col_o,
  output gopen_pkg::slot_t              slot_o
);

  localparam int W_RST = (gopen_pkg::W_RESET > MAX_WIDTH) ? MAX_WIDTH : gopen_pkg::W_RESET;
  localparam int SW    = gopen_pkg::SUM_W;

  logic [WVW-1:0]                 wv_q;
  logic [gopen_pkg::FH_W-1:0]     hv_q;
  logic [gopen_pkg::ROW_W-1:0]    row_q;
  logic [CW-1:0]                  col_q;

  logic [WVW-1:0]                 wv_cfg;
  logic [gopen_pkg::FH_W-1:0]     hv_cfg;
  logic [31:0]                    fw_sat;
  logic [gopen_pkg::FH_W-1:0]     fh_raw;

  logic [SW-1:0] r;
  logic [SW-1:0] c;
  logic [SW-1:0] w;
  logic [SW-1:0] h;
  logic [SW-1:0] b;
  logic [SW-1:0] oc;
  logic [SW-1:0] orr;
  logic          c_ge2;
  logic          pix_slot;
  logic          last_slot;
  logic          line_end;

  // Saturate the geometry on the way in
  always_comb begin
    fw_sat = 32'(cfg_data_i[gopen_pkg::FW_W-1:0]);
    if (fw_sat < 32'(gopen_pkg::MIN_DIM)) begin
      fw_sat = 32'(gopen_pkg::MIN_DIM);
    end else if (fw_sat > 32'(MAX_WIDTH)) begin
      fw_sat = 32'(MAX_WIDTH);
    end
    wv_cfg = fw_sat[WVW-1:0];
    fh_raw = cfg_data_i[gopen_pkg::FH_W-1:0];
    hv_cfg = (fh_raw < gopen_pkg::FH_W'(gopen_pkg::MIN_DIM)) ?
             gopen_pkg::FH_W'(gopen_pkg::MIN_DIM) : fh_raw;
  end

  always_comb begin
    r = SW'(row_q);
    c = SW'(col_q);
    w = SW'(wv_q);
    h = SW'(hv_q);
    b = SW'(BORDER);

    pix_slot  = r < h;
    last_slot = (r == h + SW'(2)) && (c == SW'(1));
    line_end  = c == w - SW'(1);

    // Erosion center sits one line and one pixel back; column zero wraps onto
    // the right edge, which is never interior
    slot_o.e_int = (r >= b + SW'(1)) && (r + b <= h) &&
                   (c >= b + SW'(1)) && (c + b <= w);

    // Output center sits two lines and two pixels back
    c_ge2 = c >= SW'(2);
    oc    = c_ge2 ? c - SW'(2) : c + w - SW'(2);
    orr   = c_ge2 ? r - SW'(2) : r - SW'(3);

    slot_o.o_vld  = (r > SW'(2)) || ((r == SW'(2)) && c_ge2);
    slot_o.o_int  = (orr >= b) && (orr + b < h) && (oc >= b) && (oc + b < w);
    slot_o.o_last = (orr == h - SW'(1)) && (oc == w - SW'(1));
  end

  // Drop fill requests that land on a pixel slot
  assign admit_o = !(pix_slot && fill_i);
  assign col_o   = col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q  <= WVW'(W_RST);
      hv_q  <= gopen_pkg::FH_W'(gopen_pkg::H_RESET);
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gopen_pkg::CFG_FRAME_WIDTH:  wv_q <= wv_cfg;
        gopen_pkg::CFG_FRAME_HEIGHT: hv_q <= hv_cfg;
        default: ;
      endcase
      row_q <= '0;
      col_q <= '0;
    end else if (acc_i && admit_o) begin
      if (last_slot) begin
        row_q <= '0;
        col_q <= '0;
      end else if (line_end) begin
        row_q <= row_q + gopen_pkg::ROW_W'(1);
        col_q <= '0;
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

endmodule

FILE: rtl/grey_opening_3x3_top.sv
// Channel    Modport  Payload                       Accepted when
// pix_in     sink     pixel_in[7:0], fill           valid && ready
// pix_out    source   pixel_out[7:0], frame_last    valid && ready
// cfg        write    cfg_idx_i, cfg_data_i[12:0]   cfg_we_i
//
// One request per clock while ready is high; each result passes the stage registers
// and the output register, and its request trails its pixel by 2*width+2 requests.
// The rate is set by the single-pass pipeline and the one read and one write
// port of each line buffer, both used once per request.
// Reset is asynchronous and clears control state only; line buffers start
// undefined and need no clearing pass.
// Ready drops only while a finished result waits in the output register and
// the last stage holds another one.
module grey_opening_3x3_top #(
  parameter int MAX_WIDTH = gopen_pkg::MAX_WIDTH_DEF,
  parameter int BORDER    = gopen_pkg::BORDER_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gopen_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [gopen_pkg::CFG_DW-1:0]  cfg_data_i,
  gopen_in_if.sink                      pix_in,
  gopen_out_if.source                   pix_out
);

  localparam int CW = $clog2(MAX_WIDTH);

  // Global pipeline advance and input handshake
  logic adv;
  logic acc;
  logic admit;

  logic [CW-1:0]    col0;
  gopen_pkg::slot_t slot0;

  // Stage 1: input register, line buffer 1 read issued
  logic             v1_q;
  gopen_pkg::pix_t  pix1_q;
  logic [CW-1:0]    col1_q;
  gopen_pkg::slot_t fl1_q;

  // Stage 2: line data present, erosion window loads
  logic             v2_q;
  gopen_pkg::pix_t  pix2_q;
  logic [CW-1:0]    col2_q;
  gopen_pkg::slot_t fl2_q;

  // Stage 3: erosion, line buffer 2 read issued
  logic             v3_q;
  logic [CW-1:0]    col3_q;
  gopen_pkg::slot_t fl3_q;

  // Stage 4: eroded line data present, dilation window loads
  logic             v4_q;
  logic [CW-1:0]    col4_q;
  gopen_pkg::slot_t fl4_q;
  gopen_pkg::pix_t  ero4_q;
  gopen_pkg::pix_t  ptop4_q;

  // Stage 5: dilation and border select
  logic             v5_q;
  gopen_pkg::slot_t fl5_q;
  gopen_pkg::pix_t  ptop5_q;

  // Output register
  logic             out_v_q;
  gopen_pkg::pix_t  out_pix_q;
  logic             out_last_q;

  gopen_pkg::lpair_t lb1_rd;
  gopen_pkg::lpair_t lb1_wr;
  gopen_pkg::lpair_t lb2_rd;
  gopen_pkg::lpair_t lb2_wr;
  gopen_pkg::col3_t  win1_col;
  gopen_pkg::col3_t  win2_col;
  gopen_pkg::win_t   win1;
  gopen_pkg::win_t   win2;

  gopen_pkg::pix_t ero3;
  gopen_pkg::pix_t ptop3;
  gopen_pkg::pix_t res5;
  logic            load_out;

  // Hold everything only when stage 5 has a result and the output is still full
  assign load_out     = v5_q && fl5_q.o_vld;
  assign adv          = !(load_out && out_v_q && !pix_out.ready);
  assign pix_in.ready = adv;
  assign acc          = pix_in.valid && adv;

  gopen_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .BORDER    (BORDER)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (acc),
    .fill_i     (pix_in.fill),
    .admit_o    (admit),
    .col_o      (col0),
    .slot_o     (slot0)
  );

  // Input line delay: each word carries the two pixels above the current one
  assign lb1_wr.prev1 = pix2_q;
  assign lb1_wr.prev2 = lb1_rd.prev1;

  gopen_lbuf #(
    .DEPTH (MAX_WIDTH)
  ) u_lbuf_in (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .rd_addr_i (col1_q),
    .rd_data_o (lb1_rd),
    .wr_en_i   (adv && v2_q),
    .wr_addr_i (col2_q),
    .wr_data_i (lb1_wr)
  );

  assign win1_col.top = lb1_rd.prev2;
  assign win1_col.mid = lb1_rd.prev1;
  assign win1_col.bot = pix2_q;

  gopen_win u_win_ero (
    .clk_i   (clk_i),
    .shift_i (adv && v2_q),
    .col_i   (win1_col),
    .win_o   (win1)
  );

  // Eroded value counts as zero outside the interior; the oldest top tap is
  // the input pixel at the output position
  assign ero3  = fl3_q.e_int ? gopen_pkg::min9(win1) : gopen_pkg::PIX_ZERO;
  assign ptop3 = win1[2].top;

  assign lb2_wr.prev1 = ero4_q;
  assign lb2_wr.prev2 = lb2_rd.prev1;

  gopen_lbuf #(
    .DEPTH (MAX_WIDTH)
  ) u_lbuf_ero (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .rd_addr_i (col3_q),
    .rd_data_o (lb2_rd),
    .wr_en_i   (adv && v4_q),
    .wr_addr_i (col4_q),
    .wr_data_i (lb2_wr)
  );

  assign win2_col.top = lb2_rd.prev2;
  assign win2_col.mid = lb2_rd.prev1;
  assign win2_col.bot = ero4_q;

  gopen_win u_win_dil (
    .clk_i   (clk_i),
    .shift_i (adv && v4_q),
    .col_i   (win2_col),
    .win_o   (win2)
  );

  // Pass border pixels through unchanged
  assign res5 = fl5_q.o_int ? gopen_pkg::max9(win2) : ptop5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv) begin
        v1_q <= acc && admit;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
      end
      if (adv && load_out) begin
        out_v_q <= 1'b1;
      end else if (pix_out.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix1_q  <= pix_in.pixel_in;
      col1_q  <= col0;
      fl1_q   <= slot0;
      pix2_q  <= pix1_q;
      col2_q  <= col1_q;
      fl2_q   <= fl1_q;
      col3_q  <= col2_q;
      fl3_q   <= fl2_q;
      col4_q  <= col3_q;
      fl4_q   <= fl3_q;
      ero4_q  <= ero3;
      ptop4_q <= ptop3;
      fl5_q   <= fl4_q;
      ptop5_q <= ptop4_q;
    end
    if (adv && load_out) begin
      out_pix_q  <= res5;
      out_last_q <= fl5_q.o_last;
    end
  end

  assign pix_out.valid      = out_v_q;
  assign pix_out.pixel_out  = out_pix_q;
  assign pix_out.frame_last = out_last_q;

endmodule

FILE: rtl/gopen_chk.sv
module gopen_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] pixel_out_i,
  input logic       frame_last_i
);

  // Input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without a blocked result");

  // Nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result offered straight out of reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result request withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(pixel_out_i) && $stable(frame_last_i)))
    else $error("result payload changed while stalled");

endmodule

bind grey_opening_3x3_top gopen_chk u_gopen_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (pix_in.valid),
  .in_ready_i   (pix_in.ready),
  .out_valid_i  (pix_out.valid),
  .out_ready_i  (pix_out.ready),
  .pixel_out_i  (pix_out.pixel_out),
  .frame_last_i (pix_out.frame_last)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef gopen_pkg::pix_t pix_t;

  localparam int LINE_MAX     = gopen_pkg::MAX_WIDTH_DEF;
  localparam int RIM          = gopen_pkg::BORDER_DEF;
  localparam int RAND_ITEMS   = 170;
  // Leave a margin for the result pipeline before touching the registers
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 50_000;

  // Pixel textures for a frame: plain noise, binary blobs, flat with small
  // ripple, and flat with bright and dark specks that opening should remove
  typedef enum int unsigned {TEX_NOISE, TEX_BINARY, TEX_SMOOTH, TEX_SPECKLE} texture_e;

  typedef struct packed {
    pix_t pixel;
    logic last;
  } opened_t;

  // Tracks the frame position, both line stores and the pending opened pixels
  class opening_scoreboard;
    logic [gopen_pkg::FW_W-1:0] width_reg;
    logic [gopen_pkg::FH_W-1:0] height_reg;
    pix_t                       raw_line[3][LINE_MAX];
    pix_t                       eroded_line[3][LINE_MAX];
    int                         slot;
    opened_t                    expected_q[$];
    int unsigned                errors;
    int unsigned                results;
    int unsigned                frames;

    function new();
      width_reg  = gopen_pkg::FW_W'(gopen_pkg::W_RESET);
      height_reg = gopen_pkg::FH_W'(gopen_pkg::H_RESET);
      slot       = 0;
      errors     = 0;
      results    = 0;
      frames     = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < LINE_MAX; j++) begin
          raw_line[i][j]    = gopen_pkg::PIX_ZERO;
          eroded_line[i][j] = gopen_pkg::PIX_ZERO;
        end
      end
    endfunction

    // Clamp the geometry registers to what the block actually uses
    function int line_len();
      int w;
      w = int'(width_reg);
      if (w < gopen_pkg::MIN_DIM) w = gopen_pkg::MIN_DIM;
      if (w > LINE_MAX) w = LINE_MAX;
      return w;
    endfunction

    function int line_count();
      int h;
      h = int'(height_reg);
      if (h < gopen_pkg::MIN_DIM) h = gopen_pkg::MIN_DIM;
      return h;
    endfunction

    function int cycle_len();
      return line_len() * line_count() + 2 * line_len() + 2;
    endfunction

    function bit pixel_slot();
      return slot < line_len() * line_count();
    endfunction

    function bit interior(int r, int c, int w, int h);
      return r >= RIM && r + RIM < h && c >= RIM && c + RIM < w;
    endfunction

    function pix_t erode3(int r, int c);
      pix_t m;
      pix_t v;
      m = 8'hFF;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          v = raw_line[(r + dr) % 3][c + dc];
          if (v < m) m = v;
        end
      end
      return m;
    endfunction

    function pix_t dilate3(int r, int c);
      pix_t m;
      pix_t v;
      m = gopen_pkg::PIX_ZERO;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          v = eroded_line[(r + dr) % 3][c + dc];
          if (v > m) m = v;
        end
      end
      return m;
    endfunction

    // Any register write restarts the frame cycle
    function void write_reg(logic [gopen_pkg::CFG_IW-1:0] idx,
                            logic [gopen_pkg::CFG_DW-1:0] val);
      if (idx == gopen_pkg::CFG_FRAME_WIDTH) begin
        width_reg = val[gopen_pkg::FW_W-1:0];
      end else if (idx == gopen_pkg::CFG_FRAME_HEIGHT) begin
        height_reg = val[gopen_pkg::FH_W-1:0];
      end
      slot = 0;
    endfunction

    // Advance one slot; returns 0 when the request is a fill that gets ignored
    function bit note_request(pix_t px, logic fl);
      int      w;
      int      h;
      int      npix;
      int      e;
      int      o;
      opened_t res;
      w    = line_len();
      h    = line_count();
      npix = w * h;
      if (slot >= npix + 2 * w + 2) slot = 0;
      if (slot < npix) begin
        if (fl) return 1'b0;
        raw_line[(slot / w) % 3][slot % w] = px;
      end
      if (slot >= w + 1) begin
        e = slot - w - 1;
        if (e < npix) begin
          eroded_line[(e / w) % 3][e % w] =
            interior(e / w, e % w, w, h) ? erode3(e / w, e % w) : gopen_pkg::PIX_ZERO;
        end
      end
      if (slot >= 2 * w + 2) begin
        o = slot - 2 * w - 2;
        res.pixel = interior(o / w, o % w, w, h) ? dilate3(o / w, o % w)
                                                 : raw_line[(o / w) % 3][o % w];
        res.last  = (o + 1 == npix);
        expected_q.push_back(res);
      end
      slot++;
      if (slot >= npix + 2 * w + 2) slot = 0;
      return 1'b1;
    endfunction

    function void check_result(pix_t px, logic last);
      opened_t want;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, pixel_out %0d frame_last %0b", $time, px, last);
        return;
      end
      want = expected_q.pop_front();
      if (want.last) frames++;
      if (px !== want.pixel) begin
        errors++;
        $display("%0t: pixel_out expected %0d actual %0d", $time, want.pixel, px);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: frame_last expected %0b actual %0b", $time, want.last, last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [gopen_pkg::CFG_IW-1:0] cfg_idx_i;
  logic [gopen_pkg::CFG_DW-1:0] cfg_data_i;

  gopen_in_if  pix_in_bus ();
  gopen_out_if pix_out_bus ();

  grey_opening_3x3_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_in     (pix_in_bus),
    .pix_out    (pix_out_bus)
  );

  opening_scoreboard sb;
  int unsigned       cycle_count;
  int unsigned       requests;
  int unsigned       rand_items;
  bit                in_steady;
  bit                out_steady;
  texture_e          frame_tex;
  pix_t              frame_base;

  // Opening of a directed frame: both pixel extremes, mid-scale neighbors,
  // single-bit patterns, and fill requests that land in pixel slots
  pix_t dir_pix[20]  = '{8'h00, 8'hFF, 8'h5A, 8'hFF, 8'h80,
                         8'h7F, 8'h01, 8'hFE, 8'hA5, 8'hFF,
                         8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                         8'hFF, 8'h55, 8'hAA, 8'hFF, 8'hFF};
  logic dir_fill[20] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run; a hung handshake ends here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still pending",
               $time, cycle_count, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result sink: draw a stall per result, with runs of steady ready between
  initial begin : result_sink
    int unsigned stall;
    pix_out_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 31) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        pix_out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pix_out_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (pix_out_bus.valid !== 1'b1) @(posedge clk_i);
      sb.check_result(pix_out_bus.pixel_out, pix_out_bus.frame_last);
    end
  end

  function automatic pix_t pick_pixel(texture_e tex, pix_t base);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (tex)
      TEX_BINARY:  return ($urandom_range(0, 2) == 0) ? 8'hFF : 8'h00;
      TEX_SMOOTH:  return base + pix_t'($urandom_range(0, 15));
      TEX_SPECKLE: return (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : base;
      default:     return pix_t'($urandom);
    endcase
  endfunction

  // Draw a register value: mostly small, sometimes below the floor or larger
  function automatic logic [gopen_pkg::CFG_DW-1:0] pick_dim(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return gopen_pkg::CFG_DW'($urandom_range(0, gopen_pkg::MIN_DIM - 1));
    if (r < 6) return gopen_pkg::CFG_DW'($urandom_range(hi + 1, hi + 8));
    return gopen_pkg::CFG_DW'($urandom_range(lo, hi));
  endfunction

  // Drive one request and hold it until accepted; report whether it moved the slot
  task automatic push_request(input pix_t px, input logic fl, output bit took);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      pix_in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_in_bus.valid    <= 1'b1;
    pix_in_bus.pixel_in <= px;
    pix_in_bus.fill     <= fl;
    @(posedge clk_i);
    while (pix_in_bus.ready !== 1'b1) @(posedge clk_i);
    took = sb.note_request(px, fl);
    requests++;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    pix_in_bus.valid <= 1'b0;
  endtask

  task automatic write_cfg(input logic [gopen_pkg::CFG_IW-1:0] idx,
                           input logic [gopen_pkg::CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Advance n slots. Pixel slots get mostly pixels and a few stray fills;
  // flush slots get mostly fills and some pixels that must be dropped.
  task automatic stream(input int unsigned n_slots, input bit counted);
    int unsigned moved;
    bit          took;
    moved = 0;
    while (moved < n_slots) begin
      if (sb.pixel_slot()) begin
        if ($urandom_range(0, 11) == 0) push_request(pix_t'($urandom), 1'b1, took);
        else push_request(pick_pixel(frame_tex, frame_base), 1'b0, took);
      end else begin
        if ($urandom_range(0, 3) == 0) push_request(pick_pixel(frame_tex, frame_base), 1'b0, took);
        else push_request(pix_t'($urandom), 1'b1, took);
      end
      if (took) begin
        moved++;
        if (counted) rand_items++;
      end
    end
  endtask

  // Drop valid, wait for every opened pixel, then let the pipeline empty
  task automatic settle();
    release_input();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase();
    logic [gopen_pkg::CFG_DW-1:0] wv;
    logic [gopen_pkg::CFG_DW-1:0] hv;
    int unsigned                  pick;
    int unsigned                  n;
    wv = pick_dim(7, 12);
    // Bit 12 lies above the width field and must be dropped
    wv[gopen_pkg::FW_W] = 1'($urandom_range(0, 1));
    hv = pick_dim(7, 10);
    pick = $urandom_range(0, 3);
    if (pick != 1) write_cfg(gopen_pkg::CFG_FRAME_WIDTH, wv);
    if (pick != 2) write_cfg(gopen_pkg::CFG_FRAME_HEIGHT, hv);
    frame_tex  = texture_e'($urandom_range(0, 3));
    frame_base = pix_t'($urandom_range(0, 240));
    case ($urandom_range(0, 4))
      0:       n = $urandom_range(1, sb.cycle_len() - 1);  // abandon mid-frame
      1:       n = 2 * sb.cycle_len();                      // back-to-back frames
      default: n = sb.cycle_len();
    endcase
    // Keep the random share of the run near its budget
    if (n > RAND_ITEMS - rand_items) n = RAND_ITEMS - rand_items;
    stream(n, 1'b1);
    settle();
  endtask

  initial begin : main_flow
    bit took;
    sb = new();
    cycle_count = 0;
    requests    = 0;
    rand_items  = 0;
    in_steady   = 1'b0;
    out_steady  = 1'b0;
    frame_tex   = TEX_NOISE;
    frame_base  = gopen_pkg::PIX_ZERO;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = gopen_pkg::CFG_FRAME_WIDTH;
    cfg_data_i  = '0;
    pix_in_bus.valid    = 1'b0;
    pix_in_bus.pixel_in = gopen_pkg::PIX_ZERO;
    pix_in_bus.fill     = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Stay inside the 2*W+2 startup at the reset geometry, where no result
    // may appear, then abandon the frame with the first register write
    stream(40, 1'b0);
    settle();

    // Directed frame at the smallest geometry
    write_cfg(gopen_pkg::CFG_FRAME_WIDTH, 13'd7);
    write_cfg(gopen_pkg::CFG_FRAME_HEIGHT, 13'd7);
    for (int i = 0; i < 20; i++) push_request(dir_pix[i], dir_fill[i], took);
    frame_tex  = TEX_SPECKLE;
    frame_base = 8'hC0;
    stream(sb.line_len() * sb.line_count() - sb.slot, 1'b0);
    // First flush slots: a pixel that must be dropped, then a plain fill
    push_request(8'hFF, 1'b0, took);
    push_request(8'h00, 1'b1, took);
    stream(sb.cycle_len() - sb.slot, 1'b0);
    // Wrap straight into a second frame with no register write
    frame_tex = TEX_BINARY;
    stream(sb.cycle_len(), 1'b0);
    settle();

    while (rand_items < RAND_ITEMS) random_phase();

    // Tallest height register at the narrowest line, abandoned partway
    write_cfg(gopen_pkg::CFG_FRAME_WIDTH, 13'd7);
    write_cfg(gopen_pkg::CFG_FRAME_HEIGHT, 13'h1FFF);
    frame_tex  = TEX_SPECKLE;
    frame_base = 8'h40;
    stream(60, 1'b0);
    settle();

    // Width register all ones saturates to the longest line; height 0 to the
    // floor. Stay inside the long startup, where no result may appear.
    write_cfg(gopen_pkg::CFG_FRAME_WIDTH, 13'h1FFF);
    write_cfg(gopen_pkg::CFG_FRAME_HEIGHT, 13'd0);
    frame_tex  = TEX_SPECKLE;
    frame_base = 8'h90;
    stream(40, 1'b0);
    settle();

    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d opened pixels never arrived", $time, sb.pending());
    end
    $display("Sent %0d requests, checked %0d opened pixels in %0d whole frames, %0d errors.",
             requests, sb.results, sb.frames, sb.errors);
    $display("Geometry ran from the clamped minimum to the longest line and tallest register.");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gopen_pkg.sv
rtl/gopen_if.sv
rtl/gopen_lbuf.sv
rtl/gopen_win.sv
rtl/gopen_ctrl.sv
rtl/grey_opening_3x3_top.sv
rtl/gopen_chk.sv
test/tb_top.sv
